/* hdl/qrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the quadratic root solver.
// No dependencies; every other file of the block imports this package.
package qrs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_GUARD = 16;

    localparam int CW  = 32;                      // coefficient and result width
    localparam int PW  = 2 * CW;                  // 32 x 32 product width
    localparam int DW  = PW + 1;                  // discriminant magnitude width
    localparam int RW  = DW + 2 * SQRT_GUARD;     // square root radicand width
    localparam int SW  = (RW + 1) / 2;            // square root result width
    localparam int BW  = CW + SQRT_GUARD + 1;     // scaled -b width, signed
    localparam int NSW = SW + 2;                  // numerator width, signed
    localparam int MW  = NSW - 1;                 // numerator magnitude width
    localparam int QW  = CW + 1;                  // quotient bits kept
    localparam int RDW = QW + CW;                 // divider remainder width
    localparam int NW  = MW + FRAC_BITS + 2;      // full dividend width
    localparam int NPW = NW - SQRT_GUARD - 2;     // dividend after common scale

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } root_kind_t;

    typedef struct packed {
        logic signed [CW-1:0] coef_a;
        logic signed [CW-1:0] coef_b;
        logic signed [CW-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        root_kind_t           root_kind;
        logic signed [CW-1:0] first_value;
        logic signed [CW-1:0] second_value;
        logic                 saturated;
    } root_t;

    // Control that rides along the square root pipeline.
    typedef struct packed {
        logic                 azero;
        logic                 dzero;
        logic                 dneg;
        logic                 aneg;
        logic [CW-1:0]        amag;
        logic signed [CW-1:0] coef_b;
    } side_t;

    // Control that rides along each divider pipeline.
    typedef struct packed {
        root_kind_t kind;
        logic       neg;
    } tag_t;

endpackage

/* hdl/qrs_disc.sv */
`timescale 1ns / 1ps
// Discriminant front end: two register stages, products then the exact b*b-4ac.
// Depends on qrs_pkg.
module qrs_disc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  qrs_pkg::coef_t    coef,
    output logic              out_valid,
    output logic [qrs_pkg::DW-1:0] disc,
    output qrs_pkg::side_t    side
);
    import qrs_pkg::*;

    logic [CW-1:0] a_u, b_u, c_u;
    logic [CW-1:0] amag, bmag, cmag;

    logic                 v1_reg;
    logic [PW-1:0]        bb_reg, ac_reg;
    logic [CW-1:0]        amag_reg;
    logic                 aneg_reg, cneg_reg;
    logic signed [CW-1:0] b_reg;

    logic [DW:0]   bb_ext, ac4;
    logic [DW:0]   d_full;
    logic          dneg_next;
    logic [DW-1:0] disc_next;
    side_t         side_next;

    logic          v2_reg;
    logic [DW-1:0] disc_reg;
    side_t         side_reg;

    always_comb
    begin
        a_u  = coef.coef_a;
        b_u  = coef.coef_b;
        c_u  = coef.coef_c;
        amag = a_u[CW-1] ? (~a_u + 1'b1) : a_u;
        bmag = b_u[CW-1] ? (~b_u + 1'b1) : b_u;
        cmag = c_u[CW-1] ? (~c_u + 1'b1) : c_u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg   <= PW'(bmag) * PW'(bmag);
            ac_reg   <= PW'(amag) * PW'(cmag);
            amag_reg <= amag;
            aneg_reg <= a_u[CW-1];
            cneg_reg <= c_u[CW-1];
            b_reg    <= coef.coef_b;
            disc_reg <= disc_next;
            side_reg <= side_next;
        end
    end

    // Opposite signs of a and c make -4ac positive, so the terms add.
    always_comb
    begin
        bb_ext    = (DW+1)'(bb_reg);
        ac4       = {ac_reg, 2'b00};
        dneg_next = 1'b0;
        if (aneg_reg != cneg_reg)
        begin
            d_full = bb_ext + ac4;
        end
        else if (bb_ext >= ac4)
        begin
            d_full = bb_ext - ac4;
        end
        else
        begin
            d_full    = ac4 - bb_ext;
            dneg_next = 1'b1;
        end
        disc_next        = d_full[DW-1:0];
        side_next.azero  = (amag_reg == '0);
        side_next.dzero  = (disc_next == '0);
        side_next.dneg   = dneg_next;
        side_next.aneg   = aneg_reg;
        side_next.amag   = amag_reg;
        side_next.coef_b = b_reg;
    end

    assign out_valid = v2_reg;
    assign disc      = disc_reg;
    assign side      = side_reg;

endmodule

/* hdl/qrs_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg.
module qrs_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [qrs_pkg::DW-1:0] disc,
    input  qrs_pkg::side_t         side_in,
    output logic                   out_valid,
    output logic [qrs_pkg::SW-1:0] root,
    output qrs_pkg::side_t         side_out
);
    import qrs_pkg::*;

    logic          v_reg    [0:SW];
    logic [RW-1:0] r_reg    [0:SW];
    logic [SW-1:0] s_reg    [0:SW];
    side_t         side_reg [0:SW];

    // The radicand is the discriminant scaled by the guard bits squared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= {disc, {(2*SQRT_GUARD){1'b0}}};
            s_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        localparam int K = SW - 1 - i;

        logic [RW-1:0] trial;
        logic [RW-1:0] r_next;
        logic [SW-1:0] s_next;
        logic          take;

        // Setting bit K adds s*2^(K+1) + 2^(2K) to the square.
        always_comb
        begin
            trial  = (RW'(s_reg[i]) << (K + 1)) | (RW'(1) << (2 * K));
            take   = (r_reg[i] >= trial);
            r_next = take ? (r_reg[i] - trial) : r_reg[i];
            s_next = take ? (s_reg[i] | (SW'(1) << K)) : s_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]    <= r_next;
                s_reg[i+1]    <= s_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign root      = s_reg[SW];
    assign side_out  = side_reg[SW];

endmodule

/* hdl/qrs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider for round(num * 2^F / (2a)), one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [qrs_pkg::MW-1:0] mag,
    input  logic [qrs_pkg::CW-1:0] amag,
    input  qrs_pkg::tag_t          tag_in,
    output logic                   out_valid,
    output logic [qrs_pkg::QW-1:0] quot,
    output logic                   ovf,
    output qrs_pkg::tag_t          tag_out
);
    import qrs_pkg::*;

    logic [NW-1:0]  n_full;
    logic [RDW-1:0] rem0;

    logic           v_reg   [0:QW];
    logic [RDW-1:0] rem_reg [0:QW];
    logic [QW-1:0]  q_reg   [0:QW];
    logic [CW-1:0]  am_reg  [0:QW];
    logic           ovf_reg [0:QW];
    tag_t           tag_reg [0:QW];

    // The half-divisor term does the rounding; the common 2^(G+2) factor is
    // dropped from dividend and divisor, which leaves the floor unchanged.
    always_comb
    begin
        n_full = (NW'(mag) << (FRAC_BITS + 1)) + (NW'(amag) << (SQRT_GUARD + 1));
        rem0   = RDW'(n_full[NW-1:SQRT_GUARD+2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0;
            q_reg[0]   <= '0;
            am_reg[0]  <= amag;
            ovf_reg[0] <= (rem0 >= {amag, {QW{1'b0}}});
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int K = QW - 1 - i;

        logic [RDW-1:0] trial;
        logic [RDW-1:0] rem_next;
        logic [QW-1:0]  q_next;
        logic           take;

        always_comb
        begin
            trial    = RDW'(am_reg[i]) << K;
            take     = (rem_reg[i] >= trial);
            rem_next = take ? (rem_reg[i] - trial) : rem_reg[i];
            q_next   = take ? (q_reg[i] | (QW'(1) << K)) : q_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_next;
                q_reg[i+1]   <= q_next;
                am_reg[i+1]  <= am_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quot      = q_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign tag_out   = tag_reg[QW];

endmodule

/* hdl/quadratic_root_solver_unit.sv */
`timescale 1ns / 1ps
// Top level of the quadratic root solver: discriminant, square root, dividers.
// Depends on qrs_pkg, qrs_disc, qrs_sqrt and qrs_div.
//
// Usage:
// The coef channel takes one equation per transaction (coef_a, coef_b, coef_c in
// signed Q16.16). A transaction completes on a rising edge with coef_valid high
// and coef_stall low. The root channel returns one result per equation, in
// order, with the same valid/stall rule: root_kind, both values in Q16.16
// rounded to nearest, and a saturation flag.
// From the accepting edge to root_valid there are two stages for
// the exact discriminant, 50 for the bit-per-stage square root, one to form the
// numerators, 34 for the bit-per-stage dividers and one output register.
// Throughput is one equation per cycle when not stalled; up to 88 are in flight.
// The whole pipeline advances on one enable. When the root channel is stalled
// with a valid result, every stage holds and coef_stall is raised in the same
// cycle, so nothing is lost or repeated; it resumes in the cycle the stall
// drops. Reset clears all valid bits at once, after which the block accepts a
// transaction in the first cycle. Equations whose leading coefficient is zero
// are flagged with their own kind and return zero values.
module quadratic_root_solver_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           coef_valid,
    output logic           coef_stall,
    input  qrs_pkg::coef_t coef,
    output logic           root_valid,
    input  logic           root_stall,
    output qrs_pkg::root_t root
);
    import qrs_pkg::*;

    logic en;

    logic          dc_valid;
    logic [DW-1:0] dc_disc;
    side_t         dc_side;

    logic          sq_valid;
    logic [SW-1:0] sq_root;
    side_t         sq_side;

    logic signed [BW-1:0]  base;
    logic signed [NSW-1:0] base_ext, s_ext, num1, num2;
    root_kind_t            kind_next;
    tag_t                  tag1_next, tag2_next;

    logic          nv_reg;
    logic [MW-1:0] mag1_reg, mag2_reg;
    logic [CW-1:0] am_reg;
    tag_t          tag1_reg, tag2_reg;

    logic          d0_valid, d1_valid;
    logic [QW-1:0] d0_quot, d1_quot;
    logic          d0_ovf, d1_ovf;
    tag_t          d0_tag, d1_tag;

    logic [CW:0]   res1, res2;
    root_t         root_next;

    logic  root_valid_reg;
    root_t root_reg;

    // Clip a quotient magnitude to the signed range and apply the sign.
    // The result holds the clip flag above the 32-bit value.
    function automatic logic [CW:0] clip_sign(input logic [QW-1:0] q, input logic ovf_in,
                                              input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] mv;
        logic          clip;
        logic [QW-1:0] sv;
        lim  = neg ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
        clip = ovf_in || (q > lim);
        mv   = clip ? lim : q;
        sv   = neg ? (~mv + QW'(1)) : mv;
        return {clip, sv[CW-1:0]};
    endfunction

    assign en         = !(root_valid_reg && root_stall);
    assign coef_stall = !en;

    qrs_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid),
        .coef      (coef),
        .out_valid (dc_valid),
        .disc      (dc_disc),
        .side      (dc_side)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dc_valid),
        .disc      (dc_disc),
        .side_in   (dc_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Numerators are in units of 2^-(16+guard): -b scaled up, plus or minus
    // the root. The complex case divides -b and the root separately.
    always_comb
    begin
        base     = -(BW'(sq_side.coef_b) <<< SQRT_GUARD);
        base_ext = NSW'(base);
        s_ext    = $signed({2'b00, sq_root});
        if (sq_side.azero)
        begin
            kind_next = KIND_A_ZERO;
            num1      = base_ext;
            num2      = base_ext;
        end
        else if (sq_side.dzero)
        begin
            kind_next = KIND_DOUBLE;
            num1      = base_ext;
            num2      = base_ext;
        end
        else if (sq_side.dneg)
        begin
            kind_next = KIND_COMPLEX;
            num1      = base_ext;
            num2      = s_ext;
        end
        else
        begin
            kind_next = KIND_TWO_REAL;
            num1      = base_ext + s_ext;
            num2      = base_ext - s_ext;
        end
        tag1_next.kind = kind_next;
        tag1_next.neg  = num1[NSW-1] ^ sq_side.aneg;
        tag2_next.kind = kind_next;
        tag2_next.neg  = num2[NSW-1] ^ sq_side.aneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg         <= 1'b0;
            root_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg         <= sq_valid;
            root_valid_reg <= d0_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= num1[NSW-1] ? MW'(-num1) : MW'(num1);
            mag2_reg <= num2[NSW-1] ? MW'(-num2) : MW'(num2);
            am_reg   <= sq_side.amag;
            tag1_reg <= tag1_next;
            tag2_reg <= tag2_next;
            root_reg <= root_next;
        end
    end

    qrs_div u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .mag       (mag1_reg),
        .amag      (am_reg),
        .tag_in    (tag1_reg),
        .out_valid (d0_valid),
        .quot      (d0_quot),
        .ovf       (d0_ovf),
        .tag_out   (d0_tag)
    );

    qrs_div u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .mag       (mag2_reg),
        .amag      (am_reg),
        .tag_in    (tag2_reg),
        .out_valid (d1_valid),
        .quot      (d1_quot),
        .ovf       (d1_ovf),
        .tag_out   (d1_tag)
    );

    // A zero leading coefficient overrides whatever the dividers produced.
    always_comb
    begin
        res1 = clip_sign(d0_quot, d0_ovf, d0_tag.neg);
        res2 = clip_sign(d1_quot, d1_ovf, d1_tag.neg);
        root_next.root_kind = d0_tag.kind;
        if (d0_tag.kind == KIND_A_ZERO)
        begin
            root_next.first_value  = '0;
            root_next.second_value = '0;
            root_next.saturated    = 1'b0;
        end
        else
        begin
            root_next.first_value  = $signed(res1[CW-1:0]);
            root_next.second_value = $signed(res2[CW-1:0]);
            root_next.saturated    = res1[CW] | res2[CW];
        end
    end

    assign root_valid = root_valid_reg;
    assign root       = root_reg;

    // The two dividers are fed together and must stay in lockstep. Tags are
    // only meaningful on stages that carry a valid equation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d0_valid == d1_valid) && (!d0_valid || (d0_tag.kind == d1_tag.kind)))
        else $error("divider pipelines out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |-> coef_stall)
        else $error("input accepted while the output is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root.root_kind == KIND_A_ZERO) |->
        (root.first_value == '0) && (root.second_value == '0) && !root.saturated)
        else $error("zero leading coefficient gave nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root.root_kind == KIND_DOUBLE) |->
        (root.first_value == root.second_value))
        else $error("double root values differ");

endmodule
